/* rtl/wcfrp_pkg.sv */
// Package: shared types and constants for the write cache flush rate policy.
package wcfrp_pkg;

  localparam int unsigned SPEED_W   = 32;
  localparam int unsigned AVG_MIN   = 655;
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_TIP   = 3'd0,
    REG_PAGE_TIP     = 3'd1,
    REG_FAST_COUNT   = 3'd2,
    REG_NORMAL_COUNT = 3'd3,
    REG_LOAD_MIN     = 3'd4,
    REG_LOAD_MAX     = 3'd5,
    REG_LOAD_LEVEL   = 3'd6,
    REG_DELAY_BASE   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    LM_NONE = 2'd0,
    LM_AGGR = 2'd1,
    LM_NORM = 2'd2
  } last_mode_t;

  typedef enum logic [1:0] {
    MODE_AGGR  = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_FLUSH = 2'd2
  } out_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SPEED_DIV,
    ST_SCAN,
    ST_AVG_DIV,
    ST_RATIO_DIV,
    ST_LOAD,
    ST_DELAY_DIV,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;      // latch request, compute avail and branch
    logic decide;       // run the decision step, set mode
    logic div_start;    // launch the shared divider
    logic [1:0] div_sel; // 0 speed, 1 average, 2 ratio, 3 delay
    logic div_take;     // latch quotient into the matching register
    logic avg_take;     // latch the average quotient
    logic scan_step;    // one table entry per cycle
    logic scan_clear;
    logic load_calc;
  } cmd_t;

  typedef struct packed {
    logic aggr;       // request takes aggressive path
    logic need_guess; // consecutive aggressive with valid time
    logic div_busy;
    logic scan_done;
    logic avg_zero;   // fewer than two entries, or average is zero
    logic need_delay; // load above level and below one
  } sts_t;

endpackage

/* rtl/wcfrp_if.sv */
// Interfaces: valid/ready channels for requests and results.
interface wcfrp_req_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] pool_size;
  logic [31:0] pool_free;
  logic [31:0] pool_used;
  logic [31:0] released_pages;
  logic [15:0] blocks_occupied;
  logic [31:0] now_seconds;
  logic [62:0] read_total;
  modport source (output valid, pool_size, pool_free, pool_used, released_pages,
                  blocks_occupied, now_seconds, read_total, input ready);
  modport sink (input valid, pool_size, pool_free, pool_used, released_pages,
                blocks_occupied, now_seconds, read_total, output ready);
endinterface

interface wcfrp_res_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [15:0] flush_blocks;
  logic [15:0] delay_units;
  logic [1:0]  mode;
  modport source (output valid, flush_blocks, delay_units, mode, input ready);
  modport sink (input valid, flush_blocks, delay_units, mode, output ready);
endinterface

/* rtl/wcfrp_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module wcfrp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [32:0] divisor,
  output logic        busy,
  output logic [47:0] quotient
);
  logic [5:0]  cnt;
  logic [47:0] q;
  logic [32:0] rem;
  logic [33:0] trial;

  assign trial    = {rem, q[47]} - {1'b0, divisor};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd48;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial[32:0];
        q   <= {q[46:0], 1'b1};
      end else begin
        rem <= {rem[31:0], q[47]};
        q   <= {q[46:0], 1'b0};
      end
    end
  end
endmodule

/* rtl/wcfrp_ctrl.sv */
// Controller: sequences one decision through the datapath.
module wcfrp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  wcfrp_pkg::sts_t sts,
  output wcfrp_pkg::cmd_t cmd
);
  import wcfrp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE:    state_next = (sts.aggr && sts.need_guess) ? ST_SPEED_DIV : ST_FINISH;
      ST_SPEED_DIV: if (!sts.div_busy) state_next = ST_SCAN;
      ST_SCAN:      if (sts.scan_done) state_next = ST_AVG_DIV;
      ST_AVG_DIV:   if (!sts.div_busy) state_next = sts.avg_zero ? ST_LOAD : ST_RATIO_DIV;
      ST_RATIO_DIV: if (!sts.div_busy) state_next = ST_LOAD;
      ST_LOAD:      state_next = sts.need_delay ? ST_DELAY_DIV : ST_FINISH;
      ST_DELAY_DIV: if (!sts.div_busy) state_next = ST_FINISH;
      ST_FINISH:    state_next = ST_OUT;
      ST_OUT:       if (out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Divider stages: the preceding state launches, the cycle the unit goes idle takes.
  always_comb begin
    cmd = '0;
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    case (state)
      ST_IDLE: begin
        cmd.capture = in_valid;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.aggr && sts.need_guess) begin
          cmd.div_start  = 1'b1;
          cmd.div_sel    = 2'd0;
        end
      end
      ST_SPEED_DIV: begin
        cmd.div_sel = 2'd0;
        if (!sts.div_busy) begin
          cmd.div_take   = 1'b1;
          cmd.scan_clear = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 2'd1;
        end
      end
      ST_AVG_DIV: begin
        cmd.div_sel = 2'd1;
        if (!sts.div_busy) begin
          cmd.avg_take = 1'b1;
          if (!sts.avg_zero) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 2'd2;
          end
        end
      end
      ST_RATIO_DIV: begin
        cmd.div_sel = 2'd2;
        if (!sts.div_busy) cmd.div_take = 1'b1;
      end
      ST_LOAD: begin
        cmd.load_calc = 1'b1;
        if (sts.need_delay) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 2'd3;
        end
      end
      ST_DELAY_DIV: begin
        cmd.div_sel = 2'd3;
        if (!sts.div_busy) cmd.div_take = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

/* rtl/wcfrp_dp.sv */
// Datapath: policy state, top-speed table, load and delay arithmetic.
module wcfrp_dp #(
  parameter int unsigned HISTORY_DEPTH  = 10,
  parameter int unsigned IDLE_CYCLE_MAX = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [wcfrp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [wcfrp_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic [31:0]     pool_size,
  input  logic [31:0]     pool_free,
  input  logic [31:0]     pool_used,
  input  logic [31:0]     released_pages,
  input  logic [15:0]     blocks_occupied,
  input  logic [31:0]     now_seconds,
  input  logic [62:0]     read_total,
  input  wcfrp_pkg::cmd_t cmd,
  output wcfrp_pkg::sts_t sts,
  output logic [15:0]     flush_blocks,
  output logic [15:0]     delay_units,
  output logic [1:0]      mode
);
  import wcfrp_pkg::*;

  localparam int unsigned HW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW = SPEED_W + CW;

  // configuration
  logic [15:0] buffer_tip, fast_count, normal_count, delay_base;
  logic [31:0] page_tip;
  logic [16:0] load_min, load_max, load_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_tip   <= 16'hFFFF;
      page_tip     <= '0;
      fast_count   <= 16'd128;
      normal_count <= 16'd1;
      load_min     <= '0;
      load_max     <= ONE_Q16;
      load_level   <= ONE_Q16;
      delay_base   <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_BUFFER_TIP:   buffer_tip   <= cfg_data[15:0];
        REG_PAGE_TIP:     page_tip     <= cfg_data;
        REG_FAST_COUNT:   fast_count   <= cfg_data[15:0];
        REG_NORMAL_COUNT: normal_count <= cfg_data[15:0];
        REG_LOAD_MIN:     load_min     <= cfg_data[16:0];
        REG_LOAD_MAX:     load_max     <= cfg_data[16:0];
        REG_LOAD_LEVEL:   load_level   <= cfg_data[16:0];
        REG_DELAY_BASE:   delay_base   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic [31:0] avail, now_r;
  logic [62:0] rd_r;
  logic        aggr_r;
  logic [31:0] avail_c;
  assign avail_c = pool_free + pool_size - pool_used + released_pages;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      avail  <= avail_c;
      now_r  <= now_seconds;
      rd_r   <= read_total;
      aggr_r <= (blocks_occupied > buffer_tip) || (avail_c < page_tip);
    end
  end

  // policy state
  last_mode_t  last_mode;
  logic        sub_steady;
  logic [3:0]  cycle_len, idle_count;
  logic [15:0] burst;
  logic [31:0] last_time, last_avail;
  logic        time_valid;
  logic [62:0] last_rd;

  // decision step (normal path fully combinational on narrow values)
  logic        n_sub;
  logic [3:0]  n_len, n_idle;
  logic [15:0] n_burst;
  logic        go;
  logic [31:0] elapsed_now;
  assign elapsed_now = now_r - last_time;

  always_comb begin
    n_sub   = sub_steady;
    n_len   = cycle_len;
    n_idle  = idle_count;
    n_burst = burst;
    go      = 1'b1;
    if (last_mode == LM_AGGR) begin
      n_len   = '0;
      n_burst = fast_count;
      n_sub   = 1'b0;
    end else if (sub_steady) begin
      n_len = 4'(IDLE_CYCLE_MAX);
    end
    if (n_idle < n_len) begin
      n_idle = n_idle + 4'd1;
      go = (n_idle >= (n_len >> 1)) && (elapsed_now >= {28'd0, n_len});
    end
    if (go) begin
      if (!n_sub) begin
        if (n_burst > normal_count && avail > last_avail) begin
          n_burst = n_burst >> 1;
          if (n_burst == normal_count) n_sub = 1'b1;
          if (n_len < 4'(IDLE_CYCLE_MAX)) n_len = n_len + 4'd1;
        end
      end else begin
        n_burst = (rd_r > last_rd) ? normal_count : fast_count;
      end
      n_idle = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode  <= LM_NONE;
      sub_steady <= 1'b1;
      cycle_len  <= '0;
      idle_count <= '0;
      burst      <= '0;
      last_time  <= '0;
      time_valid <= 1'b0;
      last_avail <= '0;
      last_rd    <= '0;
    end else if (cmd.decide) begin
      if (aggr_r) begin
        burst      <= fast_count;
        idle_count <= '0;
        last_mode  <= LM_AGGR;
        last_time  <= now_r;
        time_valid <= 1'b1;
        last_avail <= avail;
      end else begin
        last_mode  <= LM_NORM;
        sub_steady <= n_sub;
        cycle_len  <= n_len;
        idle_count <= n_idle;
        burst      <= n_burst;
        if (go) begin
          if (sub_steady && last_mode != LM_AGGR) last_rd <= rd_r;
          last_time  <= now_r;
          time_valid <= 1'b1;
          last_avail <= avail;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      mode    <= aggr_r ? MODE_AGGR : (go ? MODE_FLUSH : MODE_WAIT);
      flush_blocks <= aggr_r ? fast_count : (go ? n_burst : 16'd0);
    end
  end

  // shared divider
  logic [47:0] div_a, div_q;
  logic [32:0] div_b;
  logic        div_busy;
  logic [31:0] elapsed_r;   // elapsed at decision time, latched before last_time moves
  logic [31:0] speed, avg;
  logic        avg_ok;
  logic [16:0] ratio, load;
  logic [SW-1:0] sum;
  logic [CW-1:0] cnt;
  logic [HW:0]   scan_i;
  logic [31:0] top [HISTORY_DEPTH];
  logic [HW-1:0] min_i;

  always_ff @(posedge clk) begin
    if (cmd.capture) elapsed_r <= (now_seconds - last_time == 32'd0) ? 32'd1
                                  : now_seconds - last_time;
  end

  always_comb begin
    case (cmd.div_sel)
      2'd0:    begin div_a = {16'd0, fast_count, 16'd0}; div_b = {1'b0, elapsed_r}; end
      2'd1:    begin div_a = {{(48-SW){1'b0}}, sum};
                     div_b = {{(33-CW){1'b0}}, cnt}; end
      2'd2:    begin div_a = {speed, 16'd0};      div_b = {1'b0, avg}; end
      default: begin div_a = {16'd0, delay_base, 16'd0};
                     div_b = {16'd0, ONE_Q16 - load}; end
    endcase
  end

  wcfrp_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  // speed is fast_count<<16 / elapsed; only low 32 bits kept
  // table: scan finds the minimum before the new speed is placed
  logic speed_in;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) top[k] <= '0;
    end else if (cmd.scan_step && scan_i == (HW+1)'(HISTORY_DEPTH) && speed_in) begin
      top[min_i] <= speed;
    end
  end

  // Two passes: entries 0..D-1 find min, then index D applies insert, then
  // a second pass sums the entries 0..D-1 that exceed AVG_MIN, read from the
  // updated table, into sum and cnt.
  logic [HW:0]   pass2_i;
  logic          pass2;
  logic [31:0]   ent;
  logic          scan_done_r;
  assign speed_in = speed > top[min_i];
  assign ent = top[pass2_i[HW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_i <= (HW+1)'(1);
      min_i  <= '0;
      pass2  <= 1'b0;
      pass2_i <= '0;
      sum    <= '0;
      cnt    <= '0;
      scan_done_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!pass2) begin
        if (scan_i < (HW+1)'(HISTORY_DEPTH)) begin
          if (top[scan_i[HW-1:0]] < top[min_i]) min_i <= scan_i[HW-1:0];
          scan_i <= scan_i + (HW+1)'(1);
        end else begin
          pass2 <= 1'b1;
        end
      end else if (pass2_i < (HW+1)'(HISTORY_DEPTH)) begin
        if (ent > 32'(AVG_MIN)) begin
          sum <= sum + {{CW{1'b0}}, ent};
          cnt <= cnt + CW'(1);
        end
        pass2_i <= pass2_i + (HW+1)'(1);
        if (pass2_i == (HW+1)'(HISTORY_DEPTH - 1)) scan_done_r <= 1'b1;
      end
    end
  end
  assign sts.scan_done = scan_done_r && cmd.scan_step;

  always_ff @(posedge clk) begin
    if (cmd.div_take) begin
      case (cmd.div_sel)
        2'd0: speed <= div_q[31:0];
        2'd2: ratio <= (div_q > 48'(ONE_Q16)) ? ONE_Q16 : div_q[16:0];
        2'd3: delay_units <= (div_q > 48'd65535) ? 16'hFFFF : div_q[15:0];
        default: ;
      endcase
    end
    if (cmd.avg_take) begin
      avg    <= (cnt < CW'(2)) ? 32'd0 : div_q[31:0];
      avg_ok <= !sts.avg_zero;
    end
    if (cmd.decide) delay_units <= '0;
    if (cmd.load_calc && !sts.need_delay && load > load_level)
      delay_units <= (delay_base != 16'd0) ? 16'hFFFF : 16'd0;
  end

  logic [16:0] raw_load;
  assign sts.avg_zero = (cnt < CW'(2)) || (div_q[31:0] == 32'd0);
  assign raw_load = ONE_Q16 - ratio;
  always_comb begin
    if (!avg_ok)               load = load_min;
    else if (raw_load < load_min) load = load_min;
    else if (raw_load > load_max) load = load_max;
    else                       load = raw_load;
  end

  assign sts.aggr       = aggr_r;
  assign sts.need_guess = (last_mode == LM_AGGR) && time_valid;
  assign sts.div_busy   = div_busy;
  assign sts.need_delay = (load > load_level) && (load < ONE_Q16);
endmodule

/* rtl/write_cache_flush_rate_policy.sv */
// Top level: write cache flush rate policy decision block.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | pool counts, blocks_occupied, now_seconds, read_total
//  res     | out | valid/ready   | flush_blocks, delay_units, mode
//  cfg     | in  | cfg_we only   | cfg_idx, cfg_data
//
// One request at a time. Normal path: capture, decide and finish states, then
// output wait. Aggressive path after aggressive: the shared 48-step divider
// computes speed, then the table scan, then average, ratio and delay divides.
// Synchronous active-high reset restores register defaults and clears table.
// The result is held until taken; no new request is accepted meanwhile.
module write_cache_flush_rate_policy #(
  parameter int unsigned HISTORY_DEPTH  = 10,
  parameter int unsigned IDLE_CYCLE_MAX = 10
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [wcfrp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input logic [wcfrp_pkg::CFG_DAT_W-1:0] cfg_data,
  wcfrp_req_if.sink   req,
  wcfrp_res_if.source res
);
  import wcfrp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wcfrp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(res.valid), .out_ready(res.ready), .sts(sts), .cmd(cmd)
  );

  wcfrp_dp #(.HISTORY_DEPTH(HISTORY_DEPTH), .IDLE_CYCLE_MAX(IDLE_CYCLE_MAX)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .pool_size(req.pool_size), .pool_free(req.pool_free), .pool_used(req.pool_used),
    .released_pages(req.released_pages), .blocks_occupied(req.blocks_occupied),
    .now_seconds(req.now_seconds), .read_total(req.read_total),
    .cmd(cmd), .sts(sts), .flush_blocks(res.flush_blocks),
    .delay_units(res.delay_units), .mode(res.mode)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !req.ready) else $error("request taken while result pending");
  a_wait_no_blocks: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.mode == MODE_WAIT) |-> (res.flush_blocks == 16'd0))
    else $error("wait mode with nonzero burst");
  a_normal_no_delay: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.mode != MODE_AGGR) |-> (res.delay_units == 16'd0))
    else $error("delay in normal mode");
`endif
endmodule
